// ===== rtl/block_buffer_cache_manager_defines.svh =====
// Assertion helpers shared by the RTL of the block buffer cache manager.
`ifndef BLOCK_BUFFER_CACHE_MANAGER_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define BBCM_ASSERT_NOW(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define BBCM_ASSERT_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/bbcm_pkg.sv =====
package bbcm_pkg;

	typedef enum logic [2:0] {
		OP_ACQUIRE     = 3'd0,
		OP_MARK_FILLED = 3'd1,
		OP_RELEASE     = 3'd2,
		OP_ADD_REF     = 3'd3,
		OP_DROP_REF    = 3'd4,
		OP_TRIM        = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_TAIL,
		ST_RD,
		ST_RMW,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SM_ACQ,
		SM_GROW,
		SM_FREE
	} scan_mode_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] device_id;
		logic [31:0] block_number;
		logic [5:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [5:0] granted_slot;
		logic       was_hit;
		logic       needs_fill;
		logic       slot_freed;
		logic       pool_full;
		logic [7:0] references_now;
	} rsp_t;

	localparam logic REG_MIN_ENTRIES      = 1'b0;
	localparam logic REG_MAX_IDLE_ENTRIES = 1'b1;

	localparam int unsigned RESET_ENTRIES     = 16;
	localparam logic [6:0]  MIN_ENTRIES_FLOOR = 7'd3;
	localparam logic [6:0]  CFG_RESET_VALUE   = 7'd16;

endpackage

// ===== rtl/block_buffer_cache_manager.sv =====
// Acquire: one scan on a hit, an idle reuse or a full pool; a claim adds a sweep that moves the slot to the list tail.
// Mark, add, drop, release: a read and a read-modify-write of the slot; a release that requeues the slot adds a sweep.
// Trim: one scan per step, plus a requeue sweep per slot it claims.
// The rate is set by the single slot memory, swept one entry per cycle in list scans.
// After reset a clearing pass writes every slot of the table; requests wait for it.
`include "block_buffer_cache_manager_defines.svh"

module block_buffer_cache_manager #(
	parameter int NUM_SLOTS = 64,
	parameter int REF_BITS  = 8
) (
	input  logic           clk,
	input  logic           arst_n,

	input  logic           req_valid,
	output logic           req_ready,
	input  bbcm_pkg::req_t req,

	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bbcm_pkg::rsp_t rsp,

	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	// Widths that follow from the parameters. Each slot is one memory word holding
	// its allocated flag, contents-valid flag, reference count, list rank and tag.
	localparam int SW      = $clog2(NUM_SLOTS);
	localparam int CW      = $clog2(NUM_SLOTS + 1);
	localparam int CMW     = (CW > 7) ? CW : 7;
	localparam int IW      = (SW > 6) ? SW : 6;
	localparam int RW      = (REF_BITS > 8) ? REF_BITS : 8;
	localparam int EW      = 2 + REF_BITS + SW + 64;
	localparam int RST_CNT = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;

	localparam logic [SW-1:0]       LAST_SLOT = SW'(NUM_SLOTS - 1);
	localparam logic [SW:0]         SLOT_CNT  = (SW + 1)'(NUM_SLOTS);
	localparam logic [REF_BITS-1:0] REF_MAX   = {REF_BITS{1'b1}};
	localparam logic [IW:0]         SLOT_LIM  = (IW + 1)'(NUM_SLOTS);

	function automatic logic [EW-1:0] pack_entry(input logic a, input logic v,
			input logic [REF_BITS-1:0] r, input logic [SW-1:0] k,
			input logic [31:0] d, input logic [31:0] b);
		return {a, v, r, k, d, b};
	endfunction

	function automatic logic [EW-1:0] set_rank(input logic [EW-1:0] e, input logic [SW-1:0] k);
		logic [EW-1:0] t;
		t = e;
		t[SW+63:64] = k;
		return t;
	endfunction

	function automatic logic [5:0] slot_out(input logic [SW-1:0] s);
		logic [IW-1:0] t;
		t = IW'(s);
		return t[5:0];
	endfunction

	function automatic logic [7:0] refs_out(input logic [REF_BITS-1:0] r);
		logic [RW-1:0] t;
		t = RW'(r);
		return t[7:0];
	endfunction

	// Control state.
	bbcm_pkg::state_t     state_q, state_d;
	bbcm_pkg::scan_mode_t mode_q, mode_d;
	logic [SW:0]          cnt_q, cnt_d;
	logic                 v_s1;
	logic [SW-1:0]        a_s1;
	logic [CW-1:0]        alloc_cnt_q, idle_cnt_q;
	logic [6:0]           min_entries_q, max_idle_q;
	logic                 rsp_valid_q;

	// Scan results: oldest match, oldest idle slot, lowest-numbered free slot.
	logic                 fnd_v_q, idl_v_q, free_v_q;
	logic [SW-1:0]        fnd_slot_q, idl_slot_q, free_slot_q, free_rank_q;
	logic [EW-1:0]        fnd_entry_q, idl_entry_q;

	// Payload registers.
	bbcm_pkg::req_t       req_q;
	bbcm_pkg::rsp_t       res_q, rsp_q, res_d;
	logic [SW-1:0]        tail_slot_q, tail_rank_q, tail_slot_d, tail_rank_d;
	logic [EW-1:0]        tail_entry_q, tail_entry_d;

	// Memory ports.
	logic                 ram_we;
	logic [SW-1:0]        ram_waddr, ram_raddr;
	logic [EW-1:0]        ram_wdata, ram_rdata;

	// Fields of the word read back from the memory.
	logic                 e_alloc, e_valid;
	logic [REF_BITS-1:0]  e_refs;
	logic [SW-1:0]        e_rank;
	logic [31:0]          e_dev, e_blk;

	assign e_alloc = ram_rdata[EW-1];
	assign e_valid = ram_rdata[EW-2];
	assign e_refs  = ram_rdata[EW-3 -: REF_BITS];
	assign e_rank  = ram_rdata[SW+63:64];
	assign e_dev   = ram_rdata[63:32];
	assign e_blk   = ram_rdata[31:0];

	// Strobes and decode.
	logic                 res_ld, tail_ld;
	logic                 alloc_inc, alloc_dec, idle_inc, idle_dec;
	logic                 sweep_rd, sweep_done, over_limits, grow_ok, free_ok, idx_ok;
	logic                 scan_match;
	logic [IW-1:0]        idx_ext;
	logic [SW-1:0]        idx_slot;
	bbcm_pkg::op_t        op;
	logic [REF_BITS-1:0]  hit_refs;
	logic                 m_alloc, m_valid, m_tail, m_free, m_idle_inc, m_idle_dec;
	logic [REF_BITS-1:0]  m_refs;

	bbcm_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Decode shared by the next-state and output logic.
	always_comb begin
		op          = bbcm_pkg::op_t'(req_q.operation);
		idx_ext     = IW'(req_q.slot_index);
		idx_slot    = SW'(idx_ext);
		idx_ok      = {1'b0, idx_ext} < SLOT_LIM;
		sweep_rd    = (state_q == bbcm_pkg::ST_SCAN || state_q == bbcm_pkg::ST_TAIL) &&
			(cnt_q < SLOT_CNT);
		sweep_done  = v_s1 && (a_s1 == LAST_SLOT);
		over_limits = (CMW'(alloc_cnt_q) > CMW'(min_entries_q)) &&
			(CMW'(idle_cnt_q) > CMW'(max_idle_q));
		grow_ok     = (CMW'(alloc_cnt_q) < CMW'(min_entries_q)) && free_v_q;
		free_ok     = over_limits && idl_v_q;
		scan_match  = (mode_q == bbcm_pkg::SM_ACQ) && (e_dev == req_q.device_id) &&
			(e_blk == req_q.block_number);
		hit_refs    = fnd_entry_q[EW-3 -: REF_BITS];
		if (hit_refs != REF_MAX) begin
			hit_refs = hit_refs + 1'b1;
		end

		// Read-modify-write of one addressed slot.
		m_alloc    = e_alloc;
		m_valid    = e_valid;
		m_refs     = e_refs;
		m_tail     = 1'b0;
		m_free     = 1'b0;
		m_idle_inc = 1'b0;
		m_idle_dec = 1'b0;
		if (e_alloc) begin
			case (op)
				bbcm_pkg::OP_MARK_FILLED: begin
					m_valid = 1'b1;
				end
				bbcm_pkg::OP_RELEASE: begin
					if (e_refs != '0) begin
						m_refs = e_refs - 1'b1;
						if (m_refs == '0) begin
							if (over_limits) begin
								m_alloc = 1'b0;
								m_free  = 1'b1;
							end else begin
								m_tail     = 1'b1;
								m_idle_inc = 1'b1;
							end
						end
					end
				end
				bbcm_pkg::OP_ADD_REF: begin
					m_idle_dec = (e_refs == '0);
					if (e_refs != REF_MAX) begin
						m_refs = e_refs + 1'b1;
					end
				end
				bbcm_pkg::OP_DROP_REF: begin
					if (e_refs != '0) begin
						m_refs     = e_refs - 1'b1;
						m_idle_inc = (m_refs == '0);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bbcm_pkg::ST_CLEAR: begin
				if (cnt_q == SLOT_CNT - 1'b1) begin
					state_d = bbcm_pkg::ST_IDLE;
				end
			end
			bbcm_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (bbcm_pkg::op_t'(req.operation) == bbcm_pkg::OP_ACQUIRE ||
							bbcm_pkg::op_t'(req.operation) == bbcm_pkg::OP_TRIM) begin
						state_d = bbcm_pkg::ST_SCAN;
					end else begin
						state_d = bbcm_pkg::ST_RD;
					end
				end
			end
			bbcm_pkg::ST_SCAN: begin
				if (sweep_done) begin
					state_d = bbcm_pkg::ST_PICK;
				end
			end
			bbcm_pkg::ST_PICK: begin
				unique case (mode_q)
					bbcm_pkg::SM_ACQ: begin
						state_d = (!fnd_v_q && !idl_v_q && free_v_q) ?
							bbcm_pkg::ST_TAIL : bbcm_pkg::ST_DONE;
					end
					bbcm_pkg::SM_GROW: begin
						state_d = grow_ok ? bbcm_pkg::ST_TAIL : bbcm_pkg::ST_SCAN;
					end
					bbcm_pkg::SM_FREE: begin
						state_d = free_ok ? bbcm_pkg::ST_SCAN : bbcm_pkg::ST_RD;
					end
					default: begin
						state_d = bbcm_pkg::ST_DONE;
					end
				endcase
			end
			bbcm_pkg::ST_TAIL: begin
				if (sweep_done) begin
					state_d = (mode_q == bbcm_pkg::SM_GROW) ?
						bbcm_pkg::ST_SCAN : bbcm_pkg::ST_DONE;
				end
			end
			bbcm_pkg::ST_RD: begin
				state_d = idx_ok ? bbcm_pkg::ST_RMW : bbcm_pkg::ST_DONE;
			end
			bbcm_pkg::ST_RMW: begin
				state_d = m_tail ? bbcm_pkg::ST_TAIL : bbcm_pkg::ST_DONE;
			end
			bbcm_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = bbcm_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// Outputs: memory ports, result, sweep target and counter strobes.
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = a_s1;
		ram_wdata    = ram_rdata;
		ram_raddr    = cnt_q[SW-1:0];
		res_ld       = 1'b0;
		res_d        = '0;
		tail_ld      = 1'b0;
		tail_slot_d  = free_slot_q;
		tail_rank_d  = free_rank_q;
		tail_entry_d = '0;
		alloc_inc    = 1'b0;
		alloc_dec    = 1'b0;
		idle_inc     = 1'b0;
		idle_dec     = 1'b0;
		mode_d       = mode_q;
		cnt_d        = cnt_q;
		unique case (state_q)
			bbcm_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[SW-1:0];
				ram_wdata = pack_entry(32'(cnt_q) < bbcm_pkg::RESET_ENTRIES, 1'b0, '0,
					cnt_q[SW-1:0], '0, '0);
				cnt_d     = cnt_q + 1'b1;
			end
			bbcm_pkg::ST_IDLE: begin
				mode_d = (bbcm_pkg::op_t'(req.operation) == bbcm_pkg::OP_TRIM) ?
					bbcm_pkg::SM_GROW : bbcm_pkg::SM_ACQ;
			end
			bbcm_pkg::ST_SCAN: begin
				if (sweep_rd) begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			bbcm_pkg::ST_PICK: begin
				unique case (mode_q)
					bbcm_pkg::SM_ACQ: begin
						res_ld = 1'b1;
						if (fnd_v_q) begin
							// Hit: take a reference on the oldest matching slot.
							ram_we    = 1'b1;
							ram_waddr = fnd_slot_q;
							ram_wdata = pack_entry(1'b1, fnd_entry_q[EW-2], hit_refs,
								fnd_entry_q[SW+63:64], req_q.device_id, req_q.block_number);
							idle_dec  = (fnd_entry_q[EW-3 -: REF_BITS] == '0);
							res_d.granted_slot   = slot_out(fnd_slot_q);
							res_d.was_hit        = 1'b1;
							res_d.needs_fill     = !fnd_entry_q[EW-2];
							res_d.references_now = refs_out(hit_refs);
						end else if (idl_v_q) begin
							// Reuse the oldest idle slot in place; its list position stays.
							ram_we    = 1'b1;
							ram_waddr = idl_slot_q;
							ram_wdata = pack_entry(1'b1, 1'b0, REF_BITS'(1),
								idl_entry_q[SW+63:64], req_q.device_id, req_q.block_number);
							idle_dec  = 1'b1;
							res_d.granted_slot   = slot_out(idl_slot_q);
							res_d.needs_fill     = 1'b1;
							res_d.references_now = 8'd1;
						end else if (free_v_q) begin
							// Claim the lowest free slot and move it to the list tail.
							tail_ld      = 1'b1;
							tail_entry_d = pack_entry(1'b1, 1'b0, REF_BITS'(1), '0,
								req_q.device_id, req_q.block_number);
							alloc_inc    = 1'b1;
							res_d.granted_slot   = slot_out(free_slot_q);
							res_d.needs_fill     = 1'b1;
							res_d.references_now = 8'd1;
						end else begin
							res_d.pool_full = 1'b1;
						end
					end
					bbcm_pkg::SM_GROW: begin
						if (grow_ok) begin
							tail_ld      = 1'b1;
							tail_entry_d = pack_entry(1'b1, 1'b0, '0, '0, '0, '0);
							alloc_inc    = 1'b1;
							idle_inc     = 1'b1;
						end else begin
							mode_d = bbcm_pkg::SM_FREE;
						end
					end
					bbcm_pkg::SM_FREE: begin
						if (free_ok) begin
							ram_we    = 1'b1;
							ram_waddr = idl_slot_q;
							ram_wdata = {1'b0, idl_entry_q[EW-2:0]};
							alloc_dec = 1'b1;
							idle_dec  = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			bbcm_pkg::ST_TAIL: begin
				if (sweep_rd) begin
					cnt_d = cnt_q + 1'b1;
				end
				// Every slot ranked after the moved one shifts up by one place.
				if (v_s1) begin
					ram_we = 1'b1;
					if (a_s1 == tail_slot_q) begin
						ram_wdata = set_rank(tail_entry_q, LAST_SLOT);
					end else if (e_rank > tail_rank_q) begin
						ram_wdata = set_rank(ram_rdata, e_rank - 1'b1);
					end
				end
			end
			bbcm_pkg::ST_RD: begin
				ram_raddr = idx_slot;
				if (!idx_ok) begin
					res_ld             = 1'b1;
					res_d.granted_slot = req_q.slot_index;
				end
			end
			bbcm_pkg::ST_RMW: begin
				res_ld             = 1'b1;
				res_d.granted_slot = req_q.slot_index;
				if (e_alloc) begin
					ram_we    = 1'b1;
					ram_waddr = idx_slot;
					ram_wdata = pack_entry(m_alloc, m_valid, m_refs, e_rank, e_dev, e_blk);
					alloc_dec = m_free;
					idle_inc  = m_idle_inc;
					idle_dec  = m_idle_dec;
					tail_ld      = m_tail;
					tail_slot_d  = idx_slot;
					tail_rank_d  = e_rank;
					tail_entry_d = pack_entry(1'b1, m_valid, m_refs, '0, e_dev, e_blk);
					res_d.slot_freed = m_free;
					if (m_alloc) begin
						res_d.needs_fill     = !m_valid;
						res_d.references_now = refs_out(m_refs);
					end
				end
			end
			bbcm_pkg::ST_DONE: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bbcm_pkg::ST_CLEAR;
			mode_q      <= bbcm_pkg::SM_ACQ;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			alloc_cnt_q <= CW'(RST_CNT);
			idle_cnt_q  <= CW'(RST_CNT);
			rsp_valid_q <= 1'b0;
			fnd_v_q     <= 1'b0;
			idl_v_q     <= 1'b0;
			free_v_q    <= 1'b0;
			min_entries_q <= bbcm_pkg::CFG_RESET_VALUE;
			max_idle_q    <= bbcm_pkg::CFG_RESET_VALUE;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_d;
			v_s1    <= sweep_rd && (state_d == state_q);

			if (alloc_inc) begin
				alloc_cnt_q <= alloc_cnt_q + 1'b1;
			end else if (alloc_dec) begin
				alloc_cnt_q <= alloc_cnt_q - 1'b1;
			end
			if (idle_inc) begin
				idle_cnt_q <= idle_cnt_q + 1'b1;
			end else if (idle_dec) begin
				idle_cnt_q <= idle_cnt_q - 1'b1;
			end

			// A scan starts empty and keeps the oldest match and idle slot and the lowest free slot.
			if (state_q != bbcm_pkg::ST_SCAN && state_d == bbcm_pkg::ST_SCAN) begin
				fnd_v_q  <= 1'b0;
				idl_v_q  <= 1'b0;
				free_v_q <= 1'b0;
			end else if (state_q == bbcm_pkg::ST_SCAN && v_s1) begin
				if (e_alloc) begin
					if (scan_match) begin
						if (!fnd_v_q || e_rank < fnd_entry_q[SW+63:64]) begin
							fnd_v_q <= 1'b1;
						end
					end else if (e_refs == '0 &&
							(!idl_v_q || e_rank < idl_entry_q[SW+63:64])) begin
						idl_v_q <= 1'b1;
					end
				end else if (!free_v_q) begin
					free_v_q <= 1'b1;
				end
			end

			if (state_q == bbcm_pkg::ST_DONE) begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_valid_q <= 1'b1;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			// Configuration writes only store the limits; trim and release apply them. A minimum below the floor is ignored.
			if (psel && penable && pwrite) begin
				if (paddr[2] == bbcm_pkg::REG_MIN_ENTRIES) begin
					if (pwdata[6:0] >= bbcm_pkg::MIN_ENTRIES_FLOOR) begin
						min_entries_q <= pwdata[6:0];
					end
				end else begin
					max_idle_q <= pwdata[6:0];
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		a_s1 <= cnt_q[SW-1:0];
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (state_q == bbcm_pkg::ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
		if (tail_ld) begin
			tail_slot_q  <= tail_slot_d;
			tail_rank_q  <= tail_rank_d;
			tail_entry_q <= tail_entry_d;
		end
		if (state_q == bbcm_pkg::ST_SCAN && v_s1) begin
			if (e_alloc) begin
				if (scan_match) begin
					if (!fnd_v_q || e_rank < fnd_entry_q[SW+63:64]) begin
						fnd_slot_q  <= a_s1;
						fnd_entry_q <= ram_rdata;
					end
				end else if (e_refs == '0 &&
						(!idl_v_q || e_rank < idl_entry_q[SW+63:64])) begin
					idl_slot_q  <= a_s1;
					idl_entry_q <= ram_rdata;
				end
			end else if (!free_v_q) begin
				free_slot_q <= a_s1;
				free_rank_q <= e_rank;
			end
		end
	end

	assign req_ready = (state_q == bbcm_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;
	assign prdata    = {25'd0, (paddr[2] == bbcm_pkg::REG_MAX_IDLE_ENTRIES) ?
		max_idle_q : min_entries_q};

	// Every allocated slot with no reference is counted idle, so idle never exceeds allocated.
	`BBCM_ASSERT_NOW(a_idle_le_alloc, idle_cnt_q <= alloc_cnt_q, "idle count above allocated count")
	`BBCM_ASSERT_NOW(a_alloc_le_slots, alloc_cnt_q <= CW'(NUM_SLOTS), "allocated count above pool size")
	`BBCM_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready, "second request taken while busy")
	`BBCM_ASSERT_NEXT(a_done_delivers, (state_q == bbcm_pkg::ST_DONE) && (!rsp_valid_q || rsp_ready), rsp_valid_q, "finished result not presented")

endmodule

// ===== rtl/bbcm_ram.sv =====
module bbcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== verif/bbcm_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, response and register channels of the cache manager,
// keeps its own copy of the slot table and compares every response in order.
module bbcm_checker #(
	parameter int NUM_SLOTS = 64,
	parameter int REF_BITS  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  bbcm_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  bbcm_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	input  logic           pready,
	output int             fail_count,
	output int             pending
);

	localparam int unsigned REF_MAX = (1 << REF_BITS) - 1;

	bit          slot_used [NUM_SLOTS];
	logic [31:0] slot_dev  [NUM_SLOTS];
	logic [31:0] slot_blk  [NUM_SLOTS];
	int unsigned slot_refs [NUM_SLOTS];
	bit          slot_valid[NUM_SLOTS];
	int unsigned slot_rank [NUM_SLOTS];
	int unsigned used_count, idle_count, keep_min, keep_idle;

	bbcm_pkg::rsp_t expected_rsp_q[$];

	function automatic void clear_table();
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_used[s]  = s < bbcm_pkg::RESET_ENTRIES;
			slot_dev[s]   = '0;
			slot_blk[s]   = '0;
			slot_refs[s]  = 0;
			slot_valid[s] = 0;
			slot_rank[s]  = s;
		end
		used_count = (NUM_SLOTS < bbcm_pkg::RESET_ENTRIES) ? NUM_SLOTS :
			bbcm_pkg::RESET_ENTRIES;
		idle_count = used_count;
		keep_min   = bbcm_pkg::CFG_RESET_VALUE;
		keep_idle  = bbcm_pkg::CFG_RESET_VALUE;
	endfunction

	function automatic void move_to_tail(int unsigned s);
		int unsigned r;
		r = slot_rank[s];
		for (int j = 0; j < NUM_SLOTS; j++)
			if (slot_rank[j] > r)
				slot_rank[j]--;
		slot_rank[s] = NUM_SLOTS - 1;
	endfunction

	function automatic bit over_limits();
		return used_count > keep_min && idle_count > keep_idle;
	endfunction

	function automatic void take_slot(int unsigned s, logic [31:0] d, logic [31:0] b,
			int unsigned refs);
		slot_used[s]  = 1;
		slot_dev[s]   = d;
		slot_blk[s]   = b;
		slot_valid[s] = 0;
		slot_refs[s]  = refs;
		move_to_tail(s);
		used_count++;
	endfunction

	function automatic void trim_pool();
		for (int s = 0; s < NUM_SLOTS && used_count < keep_min; s++)
			if (!slot_used[s]) begin
				take_slot(s, '0, '0, 0);
				idle_count++;
			end
		for (int r = 0; r < NUM_SLOTS; r++)
			for (int s = 0; s < NUM_SLOTS; s++)
				if (slot_rank[s] == r && slot_used[s] && slot_refs[s] == 0 && over_limits()) begin
					slot_used[s] = 0;
					used_count--;
					idle_count--;
				end
	endfunction

	function automatic bbcm_pkg::rsp_t cache_response(bbcm_pkg::req_t r);
		bbcm_pkg::rsp_t e;
		int unsigned    found, idle, frank, irank, s, idx;
		e = '0;
		idx = r.slot_index;
		e.granted_slot = r.slot_index;
		if (r.operation == bbcm_pkg::OP_ACQUIRE) begin
			found = NUM_SLOTS;
			idle  = NUM_SLOTS;
			frank = NUM_SLOTS;
			irank = NUM_SLOTS;
			for (s = 0; s < NUM_SLOTS; s++) begin
				if (!slot_used[s])
					continue;
				if (slot_dev[s] == r.device_id && slot_blk[s] == r.block_number) begin
					if (slot_rank[s] < frank) begin
						frank = slot_rank[s];
						found = s;
					end
				end else if (slot_refs[s] == 0 && slot_rank[s] < irank) begin
					irank = slot_rank[s];
					idle = s;
				end
			end
			if (found < NUM_SLOTS) begin
				if (slot_refs[found] == 0)
					idle_count--;
				if (slot_refs[found] < REF_MAX)
					slot_refs[found]++;
				e.granted_slot = 6'(found);
				e.was_hit = 1;
			end else if (idle < NUM_SLOTS) begin
				slot_dev[idle]   = r.device_id;
				slot_blk[idle]   = r.block_number;
				slot_valid[idle] = 0;
				slot_refs[idle]  = 1;
				idle_count--;
				e.granted_slot = 6'(idle);
			end else begin
				for (s = 0; s < NUM_SLOTS; s++)
					if (!slot_used[s])
						break;
				if (s < NUM_SLOTS) begin
					take_slot(s, r.device_id, r.block_number, 1);
					e.granted_slot = 6'(s);
				end else begin
					e.granted_slot = '0;
					e.pool_full = 1;
				end
			end
			if (!e.pool_full) begin
				e.needs_fill     = !slot_valid[e.granted_slot];
				e.references_now = 8'(slot_refs[e.granted_slot]);
			end
		end else begin
			if (r.operation == bbcm_pkg::OP_TRIM)
				trim_pool();
			if (idx < NUM_SLOTS && slot_used[idx]) begin
				if (r.operation == bbcm_pkg::OP_MARK_FILLED) begin
					slot_valid[idx] = 1;
				end else if (r.operation == bbcm_pkg::OP_RELEASE) begin
					if (slot_refs[idx] != 0) begin
						slot_refs[idx]--;
						if (slot_refs[idx] == 0) begin
							if (over_limits()) begin
								slot_used[idx] = 0;
								used_count--;
								e.slot_freed = 1;
							end else begin
								move_to_tail(idx);
								idle_count++;
							end
						end
					end
				end else if (r.operation == bbcm_pkg::OP_ADD_REF) begin
					if (slot_refs[idx] == 0)
						idle_count--;
					if (slot_refs[idx] < REF_MAX)
						slot_refs[idx]++;
				end else if (r.operation == bbcm_pkg::OP_DROP_REF) begin
					if (slot_refs[idx] != 0) begin
						slot_refs[idx]--;
						if (slot_refs[idx] == 0)
							idle_count++;
					end
				end
				if (slot_used[idx]) begin
					e.references_now = 8'(slot_refs[idx]);
					e.needs_fill     = !slot_valid[idx];
				end
			end
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bbcm_pkg::rsp_t want;
		if (!arst_n) begin
			clear_table();
			expected_rsp_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == bbcm_pkg::REG_MIN_ENTRIES) begin
					if (pwdata[6:0] >= bbcm_pkg::MIN_ENTRIES_FLOOR)
						keep_min = pwdata[6:0];
				end else begin
					keep_idle = pwdata[6:0];
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.granted_slot !== want.granted_slot) begin
						$error("granted_slot: expected %0d, actual %0d",
							want.granted_slot, rsp.granted_slot);
						fail_count++;
					end
					if (rsp.was_hit !== want.was_hit) begin
						$error("was_hit: expected %0d, actual %0d", want.was_hit, rsp.was_hit);
						fail_count++;
					end
					if (rsp.needs_fill !== want.needs_fill) begin
						$error("needs_fill: expected %0d, actual %0d",
							want.needs_fill, rsp.needs_fill);
						fail_count++;
					end
					if (rsp.slot_freed !== want.slot_freed) begin
						$error("slot_freed: expected %0d, actual %0d",
							want.slot_freed, rsp.slot_freed);
						fail_count++;
					end
					if (rsp.pool_full !== want.pool_full) begin
						$error("pool_full: expected %0d, actual %0d",
							want.pool_full, rsp.pool_full);
						fail_count++;
					end
					if (rsp.references_now !== want.references_now) begin
						$error("references_now: expected %0d, actual %0d",
							want.references_now, rsp.references_now);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsp_q.push_back(cache_response(req));
			pending = expected_rsp_q.size();
		end
	end

endmodule

// ===== verif/tb_block_buffer_cache_manager.sv =====
`timescale 1ns / 100ps

module tb_block_buffer_cache_manager;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	bbcm_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_ready;
	bbcm_pkg::rsp_t rsp;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [2:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	int fail_count;
	int pending;

	// Stimulus controls shared between the request driver and the response side.
	bit no_idle;
	bit hold_req;
	int sent_count;

	// Ring of recently granted slots, so that releases and reference changes
	// mostly address slots that really hold a block.
	logic [5:0] recent_slot[16];
	int unsigned recent_wr;

	block_buffer_cache_manager u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	bbcm_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard limit on the run. The slowest legal run is far below this, even with
	// every trim growing the whole pool and every response held off.
	initial begin
		#100000000;
		$display("tb_block_buffer_cache_manager: FAIL");
		$finish;
	end

	initial begin
		for (int i = 0; i < 16; i++)
			recent_slot[i] = 6'(i);
		recent_wr = 0;
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready && !rsp.pool_full) begin
			recent_slot[recent_wr % 16] <= rsp.granted_slot;
			recent_wr <= recent_wr + 1;
		end
	end

	// Response side. It stalls at random about 27 times in a hundred, never while
	// the no-idle stretch runs, and once holds off for a long time so that the
	// block backs up and stops accepting requests.
	initial begin
		rsp_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				rsp_ready <= 1'b0;
				repeat (800)
					@(posedge clk);
				hold_req = 0;
			end else begin
				rsp_ready <= no_idle || ($urandom_range(99) >= 27);
				@(posedge clk);
			end
		end
	end

	// Presents one request and returns at the edge where it is accepted. A random
	// gap may come first; valid is only lowered when such a gap is taken.
	task automatic send_request(input logic [2:0] op, input logic [31:0] dev,
			input logic [31:0] blk, input logic [5:0] slot);
		bbcm_pkg::req_t r;
		r.operation    = op;
		r.device_id    = dev;
		r.block_number = blk;
		r.slot_index   = slot;
		if (!no_idle && $urandom_range(99) < 27) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(4, 1))
				@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sent_count++;
	endtask

	// Waits until every response is back, with valid low, so that registers
	// can be written while the block sits idle.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [6:0] pick_limit();
		case ($urandom_range(5))
			0: return 7'd0;
			1: return 7'd3;
			2: return 7'd64;
			3: return 7'd127;
			4: return 7'd2;
			default: return 7'($urandom_range(64));
		endcase
	endfunction

	function automatic logic [5:0] pick_slot();
		if ($urandom_range(99) < 80)
			return recent_slot[$urandom_range(15)];
		return 6'($urandom_range(63));
	endfunction

	// A mixed workload over a small tag space, so that hits, idle reuse and
	// releases to the list tail all happen often.
	task automatic mixed_phase(input int count);
		int unsigned pick;
		logic [31:0] dev, blk;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if ($urandom_range(9) == 0) begin
				dev = $urandom();
				blk = $urandom();
			end else begin
				dev = $urandom_range(3);
				blk = $urandom_range(15);
			end
			if (pick < 40)
				send_request(bbcm_pkg::OP_ACQUIRE, dev, blk, 6'($urandom_range(63)));
			else if (pick < 55)
				send_request(bbcm_pkg::OP_MARK_FILLED, $urandom(), $urandom(), pick_slot());
			else if (pick < 75)
				send_request(bbcm_pkg::OP_RELEASE, $urandom(), $urandom(), pick_slot());
			else if (pick < 83)
				send_request(bbcm_pkg::OP_ADD_REF, $urandom(), $urandom(), pick_slot());
			else if (pick < 93)
				send_request(bbcm_pkg::OP_DROP_REF, $urandom(), $urandom(), pick_slot());
			else if (pick < 97)
				send_request(bbcm_pkg::OP_TRIM, $urandom(), $urandom(), pick_slot());
			else
				send_request(3'($urandom_range(7, 6)), $urandom(), $urandom(), pick_slot());
		end
	endtask

	initial begin
		logic [5:0] sat_slot;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		no_idle    = 0;
		hold_req   = 0;
		sent_count = 0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Acquiring device 0, block 0 hits a blank slot left by reset.
		// The first all-ones acquire misses and reuses an idle slot; later ones hit.
		send_request(bbcm_pkg::OP_ACQUIRE, 32'd0, 32'd0, 6'd0);
		send_request(bbcm_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
		send_request(bbcm_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
		send_request(bbcm_pkg::OP_MARK_FILLED, 32'd0, 32'd0, 6'd1);
		send_request(bbcm_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
		send_request(bbcm_pkg::OP_ADD_REF, 32'd0, 32'd0, 6'd2);
		send_request(bbcm_pkg::OP_DROP_REF, 32'd0, 32'd0, 6'd2);
		send_request(bbcm_pkg::OP_DROP_REF, 32'd0, 32'd0, 6'd2);
		send_request(bbcm_pkg::OP_RELEASE, 32'd0, 32'd0, 6'd3);
		send_request(bbcm_pkg::OP_RELEASE, 32'd0, 32'd0, 6'd0);
		send_request(bbcm_pkg::OP_RELEASE, 32'd0, 32'd0, 6'd1);
		send_request(bbcm_pkg::OP_RELEASE, 32'd0, 32'd0, 6'd1);
		send_request(bbcm_pkg::OP_RELEASE, 32'd0, 32'd0, 6'd1);
		// Unallocated slot: every operation on it is ignored.
		send_request(bbcm_pkg::OP_RELEASE, 32'd0, 32'd0, 6'd63);
		send_request(bbcm_pkg::OP_MARK_FILLED, 32'd0, 32'd0, 6'd63);
		send_request(bbcm_pkg::OP_ADD_REF, 32'd0, 32'd0, 6'd63);
		send_request(bbcm_pkg::OP_DROP_REF, 32'd0, 32'd0, 6'd63);
		// Unused operation codes report the slot's state without changing anything.
		send_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd1);
		send_request(3'd7, 32'd0, 32'd0, 6'd63);
		send_request(bbcm_pkg::OP_TRIM, 32'd0, 32'd0, 6'd0);
		drain();

		// Tight limits, then a trim that frees idle slots down to the floor. A
		// minimum below the floor must be ignored by the block.
		reg_write({bbcm_pkg::REG_MIN_ENTRIES, 2'b00}, 32'd3);
		reg_write({bbcm_pkg::REG_MAX_IDLE_ENTRIES, 2'b00}, 32'd0);
		reg_write({bbcm_pkg::REG_MIN_ENTRIES, 2'b00}, 32'd2);
		send_request(bbcm_pkg::OP_TRIM, 32'd0, 32'd0, 6'd5);
		send_request(bbcm_pkg::OP_ACQUIRE, 32'd0, 32'd0, 6'd0);
		drain();

		// Saturate the reference count of one slot and bring it back down.
		reg_write({bbcm_pkg::REG_MIN_ENTRIES, 2'b00}, 32'd64);
		reg_write({bbcm_pkg::REG_MAX_IDLE_ENTRIES, 2'b00}, 32'd64);
		send_request(bbcm_pkg::OP_TRIM, 32'd0, 32'd0, 6'd0);
		sat_slot = 6'($urandom_range(63));
		for (int i = 0; i < 260; i++)
			send_request(bbcm_pkg::OP_ADD_REF, $urandom(), $urandom(), sat_slot);
		for (int i = 0; i < 260; i++)
			send_request(($urandom_range(1) ? bbcm_pkg::OP_RELEASE : bbcm_pkg::OP_DROP_REF),
				$urandom(), $urandom(), sat_slot);

		// The first mixed phase runs while the response side holds off, so the
		// block fills up and stalls its request channel.
		hold_req = 1;
		mixed_phase(100);

		while (sent_count < 1800) begin
			// The sender pauses here until every outstanding response is back.
			drain();
			reg_write({bbcm_pkg::REG_MIN_ENTRIES, 2'b00}, {25'd0, pick_limit()});
			reg_write({bbcm_pkg::REG_MAX_IDLE_ENTRIES, 2'b00}, {25'd0, pick_limit()});
			if ($urandom_range(1))
				send_request(bbcm_pkg::OP_TRIM, $urandom(), $urandom(), 6'($urandom_range(63)));
			no_idle = ($urandom_range(5) == 0);
			if ($urandom_range(3) == 0) begin
				// Distinct random tags with no releases run the pool out of
				// slots, then everything is handed back.
				for (int i = 0; i < 70; i++)
					send_request(bbcm_pkg::OP_ACQUIRE, $urandom(), $urandom(),
						6'($urandom_range(63)));
				for (int s = 0; s < 64; s++)
					send_request(bbcm_pkg::OP_RELEASE, $urandom(), $urandom(), 6'(s));
			end else begin
				mixed_phase(120);
			end
			no_idle = 0;
		end

		drain();
		repeat (300)
			@(posedge clk);
		if (fail_count == 0)
			$display("tb_block_buffer_cache_manager: PASS");
		else
			$display("tb_block_buffer_cache_manager: FAIL");
		$finish;
	end

endmodule

// ===== block_buffer_cache_manager.f =====
+incdir+rtl
rtl/bbcm_pkg.sv
rtl/bbcm_ram.sv
rtl/block_buffer_cache_manager.sv
verif/bbcm_checker.sv
verif/tb_block_buffer_cache_manager.sv
